[design/awq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awq_pkg: shared constants for the affine bilinear warp block
// Image geometry, fixed-point formats, register indexes and command codes.
// ----------------------------------------------------------------------------
package awq_pkg;

	// image geometry
	localparam int IMAGE_SIDE = 28;
	localparam int PIXELS     = IMAGE_SIDE * IMAGE_SIDE;
	localparam int ADDR_W     = $clog2(PIXELS);
	localparam int CENTER     = IMAGE_SIDE / 2;
	localparam int ROW_W      = 5;

	// fixed-point formats
	localparam int FRAC_BITS  = 15;
	localparam int ONE_Q15    = 1 << FRAC_BITS;
	localparam int BUCKET_MAX = 256;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_BUCKET_COUNT    = 3'd0;
	localparam logic [2:0] REG_ROW_SCALE_DELTA = 3'd1;
	localparam logic [2:0] REG_ROW_SHEAR       = 3'd2;
	localparam logic [2:0] REG_COL_SHEAR       = 3'd3;
	localparam logic [2:0] REG_COL_SCALE_DELTA = 3'd4;

	// input word kinds
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_WARP = 1'b1;

endpackage

[design/affine_bilinear_warp_quantize.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_bilinear_warp_quantize: affine warp with bilinear blend and bucketing
// Holds a 28x28 grey image; warp words map an output pixel through the
// configured affine matrix and return a quantized bilinear blend.
// ----------------------------------------------------------------------------
// A load word (tuser = 0) writes one pixel and leaves s_tready high; loads
// outside the image are dropped. A warp word (tuser = 1) has its result
// written to the output register as s_tready returns, so a new warp is not
// taken before the last one is through: one shared 25x18 signed multiplier
// runs eleven products in turn (four for the source coordinates, six for the
// bilinear blend, one for the bucket scaling), and the single-port image
// store is read four times for the neighbours.
// s_tready is low while a warp is in progress; a finished result waiting on
// m_tready does not stop the next word from being taken until the following
// warp needs the output register, and that warp then holds its last step
// until the output register frees. Neighbours outside the image read as zero.
// Pixels that were never loaded read as unknown values.
// ----------------------------------------------------------------------------
module affine_bilinear_warp_quantize (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [4:0] row, [9:5] col, [17:10] pixel_in
	input  logic [0:0]  s_tuser,   // [0] cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] bucket_value
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// sequencer codes
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	localparam logic [4:0] STEP_ROW_A   = 5'd0;
	localparam logic [4:0] STEP_ROW_B   = 5'd1;
	localparam logic [4:0] STEP_COL_A   = 5'd2;
	localparam logic [4:0] STEP_COL_B   = 5'd3;
	localparam logic [4:0] STEP_COORD   = 5'd5;
	localparam logic [4:0] STEP_RD_00   = 5'd6;
	localparam logic [4:0] STEP_RD_10   = 5'd7;
	localparam logic [4:0] STEP_RD_01   = 5'd8;
	localparam logic [4:0] STEP_RD_11   = 5'd9;
	localparam logic [4:0] STEP_TOP_A   = 5'd8;
	localparam logic [4:0] STEP_TOP_B   = 5'd9;
	localparam logic [4:0] STEP_BOT_A   = 5'd10;
	localparam logic [4:0] STEP_BOT_B   = 5'd11;
	localparam logic [4:0] STEP_BLEND_A = 5'd12;
	localparam logic [4:0] STEP_BLEND_B = 5'd13;
	localparam logic [4:0] STEP_BUCKET  = 5'd15;
	localparam logic [4:0] STEP_DONE    = 5'd16;

	// accumulator destinations of a product
	localparam logic [2:0] DST_NONE  = 3'd0;
	localparam logic [2:0] DST_ROW   = 3'd1;
	localparam logic [2:0] DST_COL   = 3'd2;
	localparam logic [2:0] DST_TOP   = 3'd3;
	localparam logic [2:0] DST_BOT   = 3'd4;
	localparam logic [2:0] DST_BLEND = 3'd5;

	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int COORD_W = 24;
	localparam int BLEND_W = 39;
	localparam int POS_W   = 10;

	// input word fields
	logic                 in_cmd;
	logic [4:0]           in_row;
	logic [4:0]           in_col;
	logic [7:0]           in_pixel;
	logic                 in_accept;

	// control state
	logic                 state_q;
	logic [4:0]           step_q;
	logic [2:0]           dest_q;
	logic                 m_tvalid_q;
	logic                 out_free;

	// configuration
	logic [8:0]           bucket_count_q;
	logic signed [15:0]   row_scale_delta_q;
	logic signed [15:0]   row_shear_q;
	logic signed [15:0]   col_shear_q;
	logic signed [15:0]   col_scale_delta_q;
	logic                 cfg_write;
	logic [8:0]           bucket_sat;

	// datapath
	logic signed [6:0]    dr_q;
	logic signed [6:0]    dc_q;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic                 mul_en;
	logic [2:0]           mul_dest;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [COORD_W-1:0] rq_q;
	logic signed [COORD_W-1:0] cq_q;
	logic [23:0]          top_q;
	logic [23:0]          bot_q;
	logic [BLEND_W-1:0]   blend_q;
	logic signed [POS_W-1:0]   fr_q;
	logic signed [POS_W-1:0]   fc_q;
	logic signed [POS_W-1:0]   cr_q;
	logic signed [POS_W-1:0]   cc_q;
	logic [awq_pkg::FRAC_BITS-1:0] dx_q;
	logic [awq_pkg::FRAC_BITS-1:0] dy_q;
	logic [15:0]          one_minus_dx;
	logic [15:0]          one_minus_dy;
	logic signed [16:0]   row_scale;
	logic signed [16:0]   col_scale;
	logic [8:0]           blend_int;
	logic [7:0]           blend_val;
	logic [7:0]           p00_q;
	logic [7:0]           p10_q;
	logic [7:0]           p01_q;
	logic [7:0]           p11_q;
	logic [7:0]           tdata_q;

	// image store
	logic [7:0]           img_mem [awq_pkg::PIXELS];
	logic [7:0]           rd_data_q;
	logic                 rd_ok_q;
	logic signed [POS_W-1:0]   rd_r;
	logic signed [POS_W-1:0]   rd_c;
	logic                 rd_ok;
	logic [awq_pkg::ADDR_W-1:0] rd_addr;
	logic [awq_pkg::ADDR_W-1:0] wr_addr;
	logic [awq_pkg::ADDR_W-1:0] mem_addr;
	logic                 wr_en;
	logic                 load_in_range;

	function automatic logic on_side(input logic signed [POS_W-1:0] v);
		on_side = !v[POS_W-1] && (v < POS_W'(awq_pkg::IMAGE_SIDE));
	endfunction

	// unpack input word
	assign in_cmd    = s_tuser[0];
	assign in_row    = s_tdata[4:0];
	assign in_col    = s_tdata[9:5];
	assign in_pixel  = s_tdata[17:10];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;

	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = tdata_q;

	// register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q    <= 9'(awq_pkg::BUCKET_MAX);
			row_scale_delta_q <= '0;
			row_shear_q       <= '0;
			col_shear_q       <= '0;
			col_scale_delta_q <= '0;
		end else if (cfg_write) begin
			unique case (paddr[4:2])
				awq_pkg::REG_BUCKET_COUNT:    bucket_count_q    <= pwdata[8:0];
				awq_pkg::REG_ROW_SCALE_DELTA: row_scale_delta_q <= pwdata[15:0];
				awq_pkg::REG_ROW_SHEAR:       row_shear_q       <= pwdata[15:0];
				awq_pkg::REG_COL_SHEAR:       col_shear_q       <= pwdata[15:0];
				awq_pkg::REG_COL_SCALE_DELTA: col_scale_delta_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			awq_pkg::REG_BUCKET_COUNT:    prdata = {23'd0, bucket_count_q};
			awq_pkg::REG_ROW_SCALE_DELTA: prdata = 32'(row_scale_delta_q);
			awq_pkg::REG_ROW_SHEAR:       prdata = 32'(row_shear_q);
			awq_pkg::REG_COL_SHEAR:       prdata = 32'(col_shear_q);
			awq_pkg::REG_COL_SCALE_DELTA: prdata = 32'(col_scale_delta_q);
			default:                      prdata = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			dest_q     <= DST_NONE;
			m_tvalid_q <= 1'b0;
		end else begin
			dest_q <= mul_dest;
			// output valid: set by a finished warp, cleared when taken
			if (state_q == ST_BUSY && step_q == STEP_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_accept && in_cmd == awq_pkg::CMD_WARP) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (step_q == STEP_DONE) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand selection for the shared multiplier
	assign row_scale    = 17'sd32768 + 17'(row_scale_delta_q);
	assign col_scale    = 17'sd32768 + 17'(col_scale_delta_q);
	assign one_minus_dx = 16'(awq_pkg::ONE_Q15) - {1'b0, dx_q};
	assign one_minus_dy = 16'(awq_pkg::ONE_Q15) - {1'b0, dy_q};
	assign blend_int    = blend_q[BLEND_W-1:2*awq_pkg::FRAC_BITS];
	assign blend_val    = (blend_int > 9'd255) ? 8'd255 : blend_int[7:0];
	assign bucket_sat   = (bucket_count_q > 9'(awq_pkg::BUCKET_MAX))
		? 9'(awq_pkg::BUCKET_MAX) : bucket_count_q;

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_en   = 1'b0;
		mul_dest = DST_NONE;
		if (state_q == ST_BUSY) begin
			unique case (step_q)
				STEP_ROW_A: begin
					mul_a = MUL_A_W'(row_scale);
					mul_b = MUL_B_W'(dr_q);
					mul_en = 1'b1; mul_dest = DST_ROW;
				end
				STEP_ROW_B: begin
					mul_a = MUL_A_W'(row_shear_q);
					mul_b = MUL_B_W'(dc_q);
					mul_en = 1'b1; mul_dest = DST_ROW;
				end
				STEP_COL_A: begin
					mul_a = MUL_A_W'(col_shear_q);
					mul_b = MUL_B_W'(dr_q);
					mul_en = 1'b1; mul_dest = DST_COL;
				end
				STEP_COL_B: begin
					mul_a = MUL_A_W'(col_scale);
					mul_b = MUL_B_W'(dc_q);
					mul_en = 1'b1; mul_dest = DST_COL;
				end
				STEP_TOP_A: begin
					mul_a = MUL_A_W'({1'b0, p00_q});
					mul_b = MUL_B_W'({1'b0, one_minus_dx});
					mul_en = 1'b1; mul_dest = DST_TOP;
				end
				STEP_TOP_B: begin
					mul_a = MUL_A_W'({1'b0, p10_q});
					mul_b = MUL_B_W'({1'b0, dx_q});
					mul_en = 1'b1; mul_dest = DST_TOP;
				end
				STEP_BOT_A: begin
					mul_a = MUL_A_W'({1'b0, p01_q});
					mul_b = MUL_B_W'({1'b0, one_minus_dx});
					mul_en = 1'b1; mul_dest = DST_BOT;
				end
				STEP_BOT_B: begin
					mul_a = MUL_A_W'({1'b0, p11_q});
					mul_b = MUL_B_W'({1'b0, dx_q});
					mul_en = 1'b1; mul_dest = DST_BOT;
				end
				STEP_BLEND_A: begin
					mul_a = MUL_A_W'({1'b0, top_q});
					mul_b = MUL_B_W'({1'b0, one_minus_dy});
					mul_en = 1'b1; mul_dest = DST_BLEND;
				end
				STEP_BLEND_B: begin
					mul_a = MUL_A_W'({1'b0, bot_q});
					mul_b = MUL_B_W'({1'b0, dy_q});
					mul_en = 1'b1; mul_dest = DST_BLEND;
				end
				STEP_BUCKET: begin
					mul_a = MUL_A_W'({1'b0, blend_val});
					mul_b = MUL_B_W'({1'b0, bucket_sat});
					mul_en = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// multiplier, then accumulate in the next cycle
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (in_accept) begin
			dr_q    <= $signed({2'b00, in_row}) - 7'(awq_pkg::CENTER);
			dc_q    <= $signed({2'b00, in_col}) - 7'(awq_pkg::CENTER);
			rq_q    <= COORD_W'(awq_pkg::CENTER * awq_pkg::ONE_Q15);
			cq_q    <= COORD_W'(awq_pkg::CENTER * awq_pkg::ONE_Q15);
			top_q   <= '0;
			bot_q   <= '0;
			blend_q <= '0;
		end else begin
			unique case (dest_q)
				DST_ROW:   rq_q    <= rq_q + prod_q[COORD_W-1:0];
				DST_COL:   cq_q    <= cq_q + prod_q[COORD_W-1:0];
				DST_TOP:   top_q   <= top_q + prod_q[23:0];
				DST_BOT:   bot_q   <= bot_q + prod_q[23:0];
				DST_BLEND: blend_q <= blend_q + prod_q[BLEND_W-1:0];
				default: ;
			endcase
		end
		// floor, fraction and ceiling of the source position
		if (state_q == ST_BUSY && step_q == STEP_COORD) begin
			fr_q <= POS_W'($signed(rq_q[COORD_W-1:awq_pkg::FRAC_BITS]));
			fc_q <= POS_W'($signed(cq_q[COORD_W-1:awq_pkg::FRAC_BITS]));
			cr_q <= POS_W'($signed(rq_q[COORD_W-1:awq_pkg::FRAC_BITS]))
				+ POS_W'(rq_q[awq_pkg::FRAC_BITS-1:0] != '0);
			cc_q <= POS_W'($signed(cq_q[COORD_W-1:awq_pkg::FRAC_BITS]))
				+ POS_W'(cq_q[awq_pkg::FRAC_BITS-1:0] != '0);
			dx_q <= rq_q[awq_pkg::FRAC_BITS-1:0];
			dy_q <= cq_q[awq_pkg::FRAC_BITS-1:0];
		end
		// neighbour capture, zero when outside the image
		if (state_q == ST_BUSY) begin
			unique case (step_q)
				STEP_RD_10: p00_q <= rd_ok_q ? rd_data_q : 8'd0;
				STEP_RD_01: p10_q <= rd_ok_q ? rd_data_q : 8'd0;
				STEP_RD_11: p01_q <= rd_ok_q ? rd_data_q : 8'd0;
				STEP_BOT_A: p11_q <= rd_ok_q ? rd_data_q : 8'd0;
				default: ;
			endcase
		end
		// output register
		if (state_q == ST_BUSY && step_q == STEP_DONE && out_free) begin
			tdata_q <= prod_q[15:8];
		end
	end

	// neighbour address selection
	always_comb begin
		unique case (step_q)
			STEP_RD_00: begin rd_r = fr_q; rd_c = fc_q; end
			STEP_RD_10: begin rd_r = cr_q; rd_c = fc_q; end
			STEP_RD_01: begin rd_r = fr_q; rd_c = cc_q; end
			STEP_RD_11: begin rd_r = cr_q; rd_c = cc_q; end
			default:    begin rd_r = fr_q; rd_c = fc_q; end
		endcase
	end

	assign rd_ok   = on_side(rd_r) && on_side(rd_c);
	assign rd_addr = rd_ok
		? awq_pkg::ADDR_W'(rd_r[awq_pkg::ROW_W-1:0])
			* awq_pkg::ADDR_W'(awq_pkg::IMAGE_SIDE)
			+ awq_pkg::ADDR_W'(rd_c[awq_pkg::ROW_W-1:0])
		: '0;

	assign load_in_range = (in_row < 5'(awq_pkg::IMAGE_SIDE))
		&& (in_col < 5'(awq_pkg::IMAGE_SIDE));
	assign wr_addr = load_in_range
		? awq_pkg::ADDR_W'(in_row) * awq_pkg::ADDR_W'(awq_pkg::IMAGE_SIDE)
			+ awq_pkg::ADDR_W'(in_col)
		: '0;
	assign wr_en    = in_accept && in_cmd == awq_pkg::CMD_LOAD && load_in_range;
	assign mem_addr = (state_q == ST_BUSY) ? rd_addr : wr_addr;

	// single-port image store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			img_mem[mem_addr] <= in_pixel;
		end
		rd_data_q <= img_mem[mem_addr];
		rd_ok_q   <= rd_ok;
	end

endmodule
